// ----- rtl/core/gte_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gte_pkg
// shared types, widths and constants of the 2d gyration tensor eigen block
// ----------------------------------------------------------------------------
package gte_pkg;

  // default build parameters
  localparam int MAX_POINTS_DEF  = 1024;
  localparam int QUEUE_DEPTH_DEF = 2;

  // field widths
  localparam int COORD_W   = 24;
  localparam int BOX_W     = 23;
  localparam int THR_W     = 20;
  localparam int MOM_W     = 58;
  localparam int XY_W      = 59;
  localparam int TOTAL_W   = 11;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_VAL_W = 23;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_BOX_LENGTH     = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ZERO_THRESHOLD = 2'd1;

  // register reset values
  localparam logic [BOX_W-1:0] BOX_LENGTH_RST     = 23'd102400;
  localparam logic [THR_W-1:0] ZERO_THRESHOLD_RST = 20'd0;

  // moment saturation limit, 2^58 - 1
  localparam logic [MOM_W-1:0] MOM_MAX = {MOM_W{1'b1}};

  typedef struct packed {
    logic signed [COORD_W-1:0] point_x;
    logic signed [COORD_W-1:0] point_y;
    logic signed [COORD_W-1:0] center_x;
    logic signed [COORD_W-1:0] center_y;
    logic                      last_point;
  } in_item_t;

  typedef struct packed {
    logic [MOM_W-1:0]   lambda_major;
    logic [MOM_W-1:0]   lambda_minor;
    logic [TOTAL_W-1:0] point_total;
    logic               count_overflow;
  } out_item_t;

  typedef struct packed {
    logic [CFG_IDX_W-1:0] index;
    logic [CFG_VAL_W-1:0] value;
  } cfg_wr_t;

  // finished sums of one cell, handed from front to back
  typedef struct packed {
    logic [MOM_W-1:0]        moment_yy;
    logic [MOM_W-1:0]        moment_xx;
    logic signed [XY_W-1:0]  moment_xy;
    logic [TOTAL_W-1:0]      point_total;
    logic                    count_overflow;
  } cell_sums_t;

  typedef enum logic [2:0] {
    BK_IDLE,
    BK_CLIP,
    BK_DIFF,
    BK_MUL,
    BK_ROOT,
    BK_DONE
  } back_state_t;

endpackage

// ----- rtl/core/gte_chan_if.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gte_chan_if
// valid/ready channel carrying one payload struct per transaction
// ----------------------------------------------------------------------------
interface gte_chan_if #(
  parameter type payload_t = logic
) ();
  logic     valid;
  logic     ready;
  payload_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// ----- rtl/core/gyration_tensor_eigen_2d_top.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gyration_tensor_eigen_2d_top
// 2x2 gyration tensor eigenvalues of one cell of points in a periodic box
// ----------------------------------------------------------------------------
// Points stream in one per cycle; each transaction carries a point, the cell
// center and a last-point flag. The front pipeline unwraps each coordinate
// by one box length when it lies half a box or more from the center, forms
// the deviations, squares them and folds them into saturating yy, xx and xy
// sums. On the last point the finished sums enter a queue of QUEUE_DEPTH
// cells and the sums clear. The back sequencer takes one cell at a time:
// threshold, difference and trace, squares through one shared 30x30
// multiplier, then a digit-by-digit square root that yields one root bit per
// cycle, sixty bits in all; that root loop bounds the work per cell. The
// front stalls only when a cell closes while the queue is full, so cells
// long enough for the back to keep up run at one point per cycle. Points
// beyond MAX_POINTS in one cell are dropped from the sums and raise
// count_overflow. No clearing pass after reset.
// ----------------------------------------------------------------------------
module gyration_tensor_eigen_2d_top #(
  parameter int MAX_POINTS  = gte_pkg::MAX_POINTS_DEF,
  parameter int QUEUE_DEPTH = gte_pkg::QUEUE_DEPTH_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  gte_chan_if.sink   in_if,
  gte_chan_if.source out_if,
  gte_chan_if.sink   cfg_if
);

  // configuration registers
  logic [gte_pkg::BOX_W-1:0] box_length_r;
  logic [gte_pkg::THR_W-1:0] zero_threshold_r;

  // cell sums between front and back
  gte_chan_if #(.payload_t(gte_pkg::cell_sums_t)) push_ch ();
  gte_chan_if #(.payload_t(gte_pkg::cell_sums_t)) pop_ch ();

  // config writes are always accepted
  assign cfg_if.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      box_length_r     <= gte_pkg::BOX_LENGTH_RST;
      zero_threshold_r <= gte_pkg::ZERO_THRESHOLD_RST;
    end else if (cfg_if.valid) begin
      unique case (cfg_if.data.index)
        gte_pkg::REG_BOX_LENGTH: begin
          box_length_r <= cfg_if.data.value[gte_pkg::BOX_W-1:0];
        end
        gte_pkg::REG_ZERO_THRESHOLD: begin
          zero_threshold_r <= cfg_if.data.value[gte_pkg::THR_W-1:0];
        end
        default: begin
          // unknown index: transaction dropped
        end
      endcase
    end
  end

  // point pipeline and accumulators
  gte_front #(
    .MAX_POINTS (MAX_POINTS)
  ) u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .box_length (box_length_r),
    .in_if      (in_if),
    .push_if    (push_ch)
  );

  // finished cells waiting for the eigen sequencer
  gte_queue #(
    .DEPTH     (QUEUE_DEPTH),
    .payload_t (gte_pkg::cell_sums_t)
  ) u_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .push_if (push_ch),
    .pop_if  (pop_ch)
  );

  // eigenvalues, one cell at a time, registered result
  gte_back u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .zero_threshold (zero_threshold_r),
    .pop_if         (pop_ch),
    .out_if         (out_if)
  );

endmodule

// ----- rtl/core/gte_front.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gte_front
// point pipeline: unwrap, deviations, products and moment accumulation
// ----------------------------------------------------------------------------
module gte_front #(
  parameter int MAX_POINTS = gte_pkg::MAX_POINTS_DEF
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic [gte_pkg::BOX_W-1:0] box_length,
  gte_chan_if.sink                 in_if,
  gte_chan_if.source               push_if
);

  localparam int CNT_W = $clog2(MAX_POINTS + 1);
  localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_POINTS);

  // periodic unwrap of one coordinate against the center
  function automatic logic signed [24:0] unwrap(
    input logic signed [23:0] p,
    input logic signed [23:0] c,
    input logic [22:0]        len
  );
    logic signed [24:0] d;
    logic [24:0]        ad;
    logic               far;
    logic signed [26:0] p2;
    logic signed [26:0] len2;
    logic signed [24:0] r;
    d    = {c[23], c} - {p[23], p};
    ad   = d[24] ? -d : d;
    far  = {ad, 1'b0} >= {3'b000, len};
    p2   = {{2{p[23]}}, p, 1'b0};
    len2 = {4'b0000, len};
    r    = {p[23], p};
    if (far) begin
      if (p2 > len2) begin
        r = r - {2'b00, len};
      end else if (p2 < len2) begin
        r = r + {2'b00, len};
      end
    end
    return r;
  endfunction

  logic advance;

  // stage 1: unwrapped coordinates
  logic               s1_valid_r;
  logic               s1_last_r;
  logic signed [24:0] s1_px_r, s1_py_r;
  logic signed [23:0] s1_cx_r, s1_cy_r;
  // stage 2: deviations
  logic               s2_valid_r;
  logic               s2_last_r;
  logic signed [25:0] s2_dx_r, s2_dy_r;
  // stage 3: products
  logic               s3_valid_r;
  logic               s3_last_r;
  logic signed [51:0] s3_yy_r, s3_xx_r, s3_xy_r;

  // running sums
  logic [gte_pkg::MOM_W-1:0]       yy_r, yy_nxt, yy_acc;
  logic [gte_pkg::MOM_W-1:0]       xx_r, xx_nxt, xx_acc;
  logic signed [gte_pkg::XY_W-1:0] xy_r, xy_nxt, xy_acc;
  logic [CNT_W-1:0]                cnt_r, cnt_nxt, cnt_acc;
  logic                            ovf_r, ovf_nxt, ovf_acc;

  logic [58:0]        yy_sum, xx_sum;
  logic signed [59:0] xy_sum;
  logic               full;

  always_comb begin
    advance      = !(s3_valid_r && s3_last_r && !push_if.ready);
    in_if.ready  = advance;
    push_if.valid = s3_valid_r && s3_last_r;

    yy_sum = {1'b0, yy_r} + {8'b0, s3_yy_r[50:0]};
    xx_sum = {1'b0, xx_r} + {8'b0, s3_xx_r[50:0]};
    xy_sum = {xy_r[58], xy_r} + {{8{s3_xy_r[51]}}, s3_xy_r};
    full   = (cnt_r == CNT_MAX);

    if (full) begin
      yy_acc  = yy_r;
      xx_acc  = xx_r;
      xy_acc  = xy_r;
      cnt_acc = cnt_r;
      ovf_acc = 1'b1;
    end else begin
      yy_acc  = yy_sum[58] ? gte_pkg::MOM_MAX : yy_sum[57:0];
      xx_acc  = xx_sum[58] ? gte_pkg::MOM_MAX : xx_sum[57:0];
      if (xy_sum[59] != xy_sum[58]) begin
        xy_acc = xy_sum[59] ? {1'b1, 58'b0} : {1'b0, {58{1'b1}}};
      end else begin
        xy_acc = xy_sum[58:0];
      end
      cnt_acc = cnt_r + 1'b1;
      ovf_acc = ovf_r;
    end

    // a cell closes on its last point: hand the sums over, start clean
    if (s3_last_r) begin
      yy_nxt  = '0;
      xx_nxt  = '0;
      xy_nxt  = '0;
      cnt_nxt = '0;
      ovf_nxt = 1'b0;
    end else begin
      yy_nxt  = yy_acc;
      xx_nxt  = xx_acc;
      xy_nxt  = xy_acc;
      cnt_nxt = cnt_acc;
      ovf_nxt = ovf_acc;
    end

    push_if.data.moment_yy      = yy_acc;
    push_if.data.moment_xx      = xx_acc;
    push_if.data.moment_xy      = xy_acc;
    push_if.data.point_total    = gte_pkg::TOTAL_W'(cnt_acc);
    push_if.data.count_overflow = ovf_acc;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
      s2_valid_r <= 1'b0;
      s3_valid_r <= 1'b0;
      yy_r       <= '0;
      xx_r       <= '0;
      xy_r       <= '0;
      cnt_r      <= '0;
      ovf_r      <= 1'b0;
    end else if (advance) begin
      s1_valid_r <= in_if.valid;
      s2_valid_r <= s1_valid_r;
      s3_valid_r <= s2_valid_r;
      if (s3_valid_r) begin
        yy_r  <= yy_nxt;
        xx_r  <= xx_nxt;
        xy_r  <= xy_nxt;
        cnt_r <= cnt_nxt;
        ovf_r <= ovf_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      s1_px_r   <= unwrap(in_if.data.point_x, in_if.data.center_x, box_length);
      s1_py_r   <= unwrap(in_if.data.point_y, in_if.data.center_y, box_length);
      s1_cx_r   <= in_if.data.center_x;
      s1_cy_r   <= in_if.data.center_y;
      s1_last_r <= in_if.data.last_point;
      s2_dx_r   <= {s1_px_r[24], s1_px_r} - {{2{s1_cx_r[23]}}, s1_cx_r};
      s2_dy_r   <= {s1_py_r[24], s1_py_r} - {{2{s1_cy_r[23]}}, s1_cy_r};
      s2_last_r <= s1_last_r;
      s3_yy_r   <= s2_dy_r * s2_dy_r;
      s3_xx_r   <= s2_dx_r * s2_dx_r;
      s3_xy_r   <= s2_dx_r * s2_dy_r;
      s3_last_r <= s2_last_r;
    end
  end

endmodule

// ----- rtl/core/gte_queue.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gte_queue
// small register fifo holding finished cell sums between front and back
// ----------------------------------------------------------------------------
module gte_queue #(
  parameter int  DEPTH     = gte_pkg::QUEUE_DEPTH_DEF,
  parameter type payload_t = gte_pkg::cell_sums_t
) (
  input  logic       clk,
  input  logic       rst_n,
  gte_chan_if.sink   push_if,
  gte_chan_if.source pop_if
);

  localparam int PTR_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);

  function automatic logic [PTR_W-1:0] bump(input logic [PTR_W-1:0] ptr);
    return (ptr == PTR_W'(DEPTH - 1)) ? '0 : ptr + 1'b1;
  endfunction

  payload_t         slots_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [CNT_W-1:0] count_r;
  logic             do_push, do_pop;

  always_comb begin
    push_if.ready = (count_r != CNT_W'(DEPTH));
    pop_if.valid  = (count_r != '0);
    pop_if.data   = slots_r[rd_ptr_r];
    do_push       = push_if.valid && push_if.ready;
    do_pop        = pop_if.valid && pop_if.ready;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= bump(wr_ptr_r);
      end
      if (do_pop) begin
        rd_ptr_r <= bump(rd_ptr_r);
      end
      if (do_push && !do_pop) begin
        count_r <= count_r + 1'b1;
      end else if (do_pop && !do_push) begin
        count_r <= count_r - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots_r[wr_ptr_r] <= push_if.data;
    end
  end

endmodule

// ----- rtl/core/gte_back.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gte_back
// per-cell sequencer: threshold, squares by partial products, digit sqrt
// ----------------------------------------------------------------------------
module gte_back (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic [gte_pkg::THR_W-1:0] zero_threshold,
  gte_chan_if.sink                  pop_if,
  gte_chan_if.source                out_if
);

  localparam int MUL_STEPS = 6;
  localparam int ROOT_BITS = 60;

  gte_pkg::back_state_t state_r, state_nxt;

  gte_pkg::cell_sums_t ent_r, ent_nxt;
  logic [57:0]         a_r, a_nxt, d_r, d_nxt;
  logic signed [58:0]  b_r, b_nxt;
  logic [58:0]         ud_r, ud_nxt, ub_r, ub_nxt, s_r, s_nxt;
  logic [2:0]          step_r, step_nxt, term_r, term_nxt;
  logic [59:0]         prod_r, prod_nxt;
  logic                prod_v_r, prod_v_nxt;
  logic [119:0]        sum_r, sum_nxt;
  logic [61:0]         rem_r, rem_nxt;
  logic [59:0]         root_r, root_nxt;
  logic [5:0]          iter_r, iter_nxt;
  gte_pkg::out_item_t  out_r, out_nxt;
  logic                out_valid_r, out_valid_nxt;

  // combinational helpers
  logic [58:0]         thr_ext, b_mag, src;
  logic signed [58:0]  diff;
  logic [1:0]          phase;
  logic [29:0]         mul_x, mul_y;
  logic [119:0]        addend;
  logic [63:0]         rem_sh, trial;
  logic [60:0]         hi_sum;
  logic signed [60:0]  lo_diff;

  always_comb begin
    state_nxt     = state_r;
    ent_nxt       = ent_r;
    a_nxt         = a_r;
    d_nxt         = d_r;
    b_nxt         = b_r;
    ud_nxt        = ud_r;
    ub_nxt        = ub_r;
    s_nxt         = s_r;
    step_nxt      = step_r;
    term_nxt      = term_r;
    prod_nxt      = prod_r;
    prod_v_nxt    = prod_v_r;
    sum_nxt       = sum_r;
    rem_nxt       = rem_r;
    root_nxt      = root_r;
    iter_nxt      = iter_r;
    out_nxt       = out_r;
    out_valid_nxt = out_valid_r && !out_if.ready;
    pop_if.ready  = 1'b0;

    thr_ext = {39'b0, zero_threshold};
    b_mag   = b_r[58] ? 59'(-b_r) : 59'(b_r);
    diff    = {1'b0, a_r} - {1'b0, d_r};

    // operand halves for the shared 30x30 multiplier
    src   = (step_r < 3'd3) ? ud_r : ub_r;
    phase = (step_r < 3'd3) ? step_r[1:0] : 2'(step_r - 3'd3);
    mul_x = (phase == 2'd0) ? src[29:0] : {1'b0, src[58:30]};
    mul_y = (phase == 2'd2) ? {1'b0, src[58:30]} : src[29:0];

    // weight of each partial product; the b terms carry the factor four
    unique case (term_r)
      3'd0:    addend = 120'(prod_r);
      3'd1:    addend = 120'(prod_r) << 31;
      3'd2:    addend = 120'(prod_r) << 60;
      3'd3:    addend = 120'(prod_r) << 2;
      3'd4:    addend = 120'(prod_r) << 33;
      3'd5:    addend = 120'(prod_r) << 62;
      default: addend = '0;
    endcase

    rem_sh  = {rem_r, sum_r[119:118]};
    trial   = {2'b00, root_r, 2'b01};
    hi_sum  = {2'b00, s_r} + {1'b0, root_r};
    lo_diff = {2'b00, s_r} - {1'b0, root_r};

    unique case (state_r)
      gte_pkg::BK_IDLE: begin
        pop_if.ready = 1'b1;
        if (pop_if.valid) begin
          ent_nxt   = pop_if.data;
          state_nxt = gte_pkg::BK_CLIP;
        end
      end
      gte_pkg::BK_CLIP: begin
        a_nxt = ({1'b0, ent_r.moment_yy} <= thr_ext) ? '0 : ent_r.moment_yy;
        d_nxt = ({1'b0, ent_r.moment_xx} <= thr_ext) ? '0 : ent_r.moment_xx;
        if (ent_r.moment_xy[58]) begin
          b_nxt = (59'(-ent_r.moment_xy) <= thr_ext) ? '0 : ent_r.moment_xy;
        end else begin
          b_nxt = (59'(ent_r.moment_xy) <= thr_ext) ? '0 : ent_r.moment_xy;
        end
        state_nxt = gte_pkg::BK_DIFF;
      end
      gte_pkg::BK_DIFF: begin
        ud_nxt     = diff[58] ? 59'(-diff) : 59'(diff);
        ub_nxt     = b_mag;
        s_nxt      = {1'b0, a_r} + {1'b0, d_r};
        step_nxt   = '0;
        prod_v_nxt = 1'b0;
        sum_nxt    = '0;
        state_nxt  = gte_pkg::BK_MUL;
      end
      gte_pkg::BK_MUL: begin
        if (prod_v_r) begin
          sum_nxt = sum_r + addend;
        end
        if (step_r != 3'(MUL_STEPS)) begin
          prod_nxt   = mul_x * mul_y;
          term_nxt   = step_r;
          prod_v_nxt = 1'b1;
          step_nxt   = step_r + 1'b1;
        end else begin
          prod_v_nxt = 1'b0;
          rem_nxt    = '0;
          root_nxt   = '0;
          iter_nxt   = '0;
          state_nxt  = gte_pkg::BK_ROOT;
        end
      end
      gte_pkg::BK_ROOT: begin
        // one root bit per cycle, two radicand bits shifted in
        if (rem_sh >= trial) begin
          rem_nxt  = 62'(rem_sh - trial);
          root_nxt = {root_r[58:0], 1'b1};
        end else begin
          rem_nxt  = rem_sh[61:0];
          root_nxt = {root_r[58:0], 1'b0};
        end
        sum_nxt  = {sum_r[117:0], 2'b00};
        iter_nxt = iter_r + 1'b1;
        if (iter_r == 6'(ROOT_BITS - 1)) begin
          state_nxt = gte_pkg::BK_DONE;
        end
      end
      gte_pkg::BK_DONE: begin
        if (!out_valid_r || out_if.ready) begin
          out_nxt.lambda_major   = (hi_sum[60:59] != 2'b00) ? gte_pkg::MOM_MAX
                                                              : hi_sum[58:1];
          out_nxt.lambda_minor   = lo_diff[60] ? '0 : lo_diff[58:1];
          out_nxt.point_total    = ent_r.point_total;
          out_nxt.count_overflow = ent_r.count_overflow;
          out_valid_nxt          = 1'b1;
          state_nxt              = gte_pkg::BK_IDLE;
        end
      end
      default: begin
        state_nxt = gte_pkg::BK_IDLE;
      end
    endcase
  end

  always_comb begin
    out_if.valid = out_valid_r;
    out_if.data  = out_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= gte_pkg::BK_IDLE;
      out_valid_r <= 1'b0;
      prod_v_r    <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      prod_v_r    <= prod_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    ent_r  <= ent_nxt;
    a_r    <= a_nxt;
    d_r    <= d_nxt;
    b_r    <= b_nxt;
    ud_r   <= ud_nxt;
    ub_r   <= ub_nxt;
    s_r    <= s_nxt;
    step_r <= step_nxt;
    term_r <= term_nxt;
    prod_r <= prod_nxt;
    sum_r  <= sum_nxt;
    rem_r  <= rem_nxt;
    root_r <= root_nxt;
    iter_r <= iter_nxt;
    out_r  <= out_nxt;
  end

endmodule
